>>> rtl/core/tte_pkg.sv
package tte_pkg;

    localparam int HANDLE_W   = 6;
    localparam int DUR_MS_W   = 22;
    localparam int TIME_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int OP_W       = 3;

    // Largest duration times 1000 still fits in 32 bits.
    localparam logic [TIME_W-1:0] US_PER_MS = 32'd1000;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 3'd0,
        OP_SET     = 3'd1,
        OP_RESTART = 3'd2,
        OP_QUERY   = 3'd3,
        OP_TICK    = 3'd4
    } op_t;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd2;

endpackage

>>> rtl/core/timer_table_expiry_unit.sv
// Table of one-shot timers driven by an internal microsecond counter.
// Input channel (s_valid/s_ready) carries one operation per transaction:
// allocate, set duration, restart, query fired, or a one-microsecond tick.
// Result channel (m_valid/m_ready) returns exactly one result per input
// transaction, in order: status, granted or echoed handle, and fired flag.
// An accepted transaction is held in the input register, then in the result
// register, before m_valid rises. With m_ready high one transaction per cycle
// is sustained: the input and result registers form a two-stage pipeline, and
// table entries are read from memory as an item enters the input register.
// When m_ready is low the result register holds; the input register still
// takes one more transaction, after which s_ready drops until the result
// is taken.
// Reset (aresetn low, synchronous) empties both stages, zeroes the time
// counter and allocation count, and marks every entry as never written, so
// it reads as start zero, duration zero and not fired. No clearing pass is
// needed; the block accepts input on the first cycle after reset.
module timer_table_expiry_unit
    import tte_pkg::*;
#(
    parameter int NUM_TIMERS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_op,
    input  logic [HANDLE_W-1:0] s_timer_handle,
    input  logic [DUR_MS_W-1:0] s_duration_ms,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [HANDLE_W-1:0] m_handle_out,
    output logic                m_fired
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int DEPTH = 1 << IDX_W;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    logic                in_valid_reg;
    logic [OP_W-1:0]     in_op_reg;
    logic [HANDLE_W-1:0] in_handle_reg;
    logic [TIME_W-1:0]   in_dur_us_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic                out_fired_reg;

    logic [TIME_W-1:0]   time_reg;
    logic [CNT_W-1:0]    alloc_cnt_reg;
    logic [DEPTH-1:0]    fired_reg;
    logic [DEPTH-1:0]    start_vld_reg;
    logic [DEPTH-1:0]    dur_vld_reg;

    logic                in_accept;
    logic                advance;
    logic [IDX_W-1:0]    idx;
    logic                handle_ok;
    logic [TIME_W-1:0]   rd_start;
    logic [TIME_W-1:0]   rd_dur_us;
    logic [TIME_W-1:0]   start_eff;
    logic [TIME_W-1:0]   dur_eff;
    logic [TIME_W-1:0]   elapsed;
    logic                expired;

    logic                start_wr_en;
    logic                dur_wr_en;
    logic                fired_set;
    logic                fired_clr;
    logic                alloc_en;
    logic                tick_en;
    logic [STATUS_W-1:0] status_next;
    logic [HANDLE_W-1:0] handle_next;
    logic                fired_next;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign in_accept = s_valid && s_ready;

    assign idx       = in_handle_reg[IDX_W-1:0];
    assign handle_ok = ({1'b0, in_handle_reg} < (HANDLE_W + 1)'(alloc_cnt_reg));

    tte_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .aclk        (aclk),
        .start_wr_en (start_wr_en),
        .dur_wr_en   (dur_wr_en),
        .wr_idx      (idx),
        .wr_start    (time_reg),
        .wr_dur_us   (in_dur_us_reg),
        .rd_en       (in_accept),
        .rd_idx      (s_timer_handle[IDX_W-1:0]),
        .rd_start    (rd_start),
        .rd_dur_us   (rd_dur_us)
    );

    // Entries never written read as their reset value of zero.
    assign start_eff = start_vld_reg[idx] ? rd_start : '0;
    assign dur_eff   = dur_vld_reg[idx] ? rd_dur_us : '0;
    assign elapsed   = time_reg - start_eff;
    assign expired   = elapsed > dur_eff;

    always_comb begin
        start_wr_en = 1'b0;
        dur_wr_en   = 1'b0;
        fired_set   = 1'b0;
        fired_clr   = 1'b0;
        alloc_en    = 1'b0;
        tick_en     = 1'b0;
        status_next = ST_OK;
        handle_next = in_handle_reg;
        fired_next  = 1'b0;
        unique case (in_op_reg)
            OP_ALLOC: begin
                if (alloc_cnt_reg >= CNT_W'(NUM_TIMERS)) begin
                    status_next = ST_FULL;
                    handle_next = '0;
                end else begin
                    handle_next = HANDLE_W'(alloc_cnt_reg);
                    alloc_en    = advance;
                end
            end
            OP_SET: begin
                if (!handle_ok) begin
                    status_next = ST_BAD_HANDLE;
                end else begin
                    dur_wr_en = advance;
                    fired_clr = advance;
                end
            end
            OP_RESTART: begin
                if (!handle_ok) begin
                    status_next = ST_BAD_HANDLE;
                end else begin
                    start_wr_en = advance;
                    fired_clr   = advance;
                end
            end
            OP_QUERY: begin
                if (!handle_ok) begin
                    status_next = ST_BAD_HANDLE;
                end else begin
                    fired_set  = advance && expired;
                    fired_next = fired_reg[idx] || expired;
                end
            end
            OP_TICK: begin
                tick_en = advance;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            time_reg      <= '0;
            alloc_cnt_reg <= '0;
            fired_reg     <= '0;
            start_vld_reg <= '0;
            dur_vld_reg   <= '0;
        end else begin
            if (in_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (tick_en) begin
                time_reg <= time_reg + 1'b1;
            end
            if (alloc_en) begin
                alloc_cnt_reg <= alloc_cnt_reg + 1'b1;
            end
            if (start_wr_en) begin
                start_vld_reg[idx] <= 1'b1;
            end
            if (dur_wr_en) begin
                dur_vld_reg[idx] <= 1'b1;
            end
            if (fired_clr) begin
                fired_reg[idx] <= 1'b0;
            end else if (fired_set) begin
                fired_reg[idx] <= 1'b1;
            end
        end
    end

    // The duration is scaled to microseconds as the transaction enters.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_op_reg     <= s_op;
            in_handle_reg <= s_timer_handle;
            in_dur_us_reg <= TIME_W'({{(TIME_W - DUR_MS_W){1'b0}}, s_duration_ms} * US_PER_MS);
        end
        if (advance) begin
            out_status_reg <= status_next;
            out_handle_reg <= handle_next;
            out_fired_reg  <= fired_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_handle_out = out_handle_reg;
    assign m_fired      = out_fired_reg;

endmodule

>>> rtl/core/tte_store.sv
module tte_store
    import tte_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3
) (
    input  logic              aclk,
    input  logic              start_wr_en,
    input  logic              dur_wr_en,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic [TIME_W-1:0] wr_start,
    input  logic [TIME_W-1:0] wr_dur_us,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_idx,
    output logic [TIME_W-1:0] rd_start,
    output logic [TIME_W-1:0] rd_dur_us
);

    logic [TIME_W-1:0] start_mem [DEPTH];
    logic [TIME_W-1:0] dur_mem   [DEPTH];
    logic [TIME_W-1:0] rd_start_reg;
    logic [TIME_W-1:0] rd_dur_reg;

    always_ff @(posedge aclk) begin
        if (start_wr_en) begin
            start_mem[wr_idx] <= wr_start;
        end
        if (dur_wr_en) begin
            dur_mem[wr_idx] <= wr_dur_us;
        end
    end

    // A write landing in the same cycle as the read is forwarded, so the
    // transaction behind it sees the updated entry.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (start_wr_en && (wr_idx == rd_idx)) begin
                rd_start_reg <= wr_start;
            end else begin
                rd_start_reg <= start_mem[rd_idx];
            end
            if (dur_wr_en && (wr_idx == rd_idx)) begin
                rd_dur_reg <= wr_dur_us;
            end else begin
                rd_dur_reg <= dur_mem[rd_idx];
            end
        end
    end

    assign rd_start  = rd_start_reg;
    assign rd_dur_us = rd_dur_reg;

endmodule

>>> rtl/core/tte_checker.sv
module tte_checker
    import tte_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [HANDLE_W-1:0] m_handle_out,
    input logic                m_fired
);

    // Nothing is shown on the result channel right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A fired flag is reported only for a successful query.
    a_fired_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_fired) |-> (m_status == ST_OK))
        else $error("fired reported with an error status");

    // A full table grants no handle.
    a_full_handle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_FULL)) |-> (m_handle_out == '0))
        else $error("full status with a nonzero handle");

    // A stalled result holds until taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)
            && $stable(m_handle_out) && $stable(m_fired)))
        else $error("stalled result changed");

    // Accepting input while the result stage is stalled fills the pipe.
    a_fill_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && m_valid && !m_ready) |=> (m_ready || !s_ready))
        else $error("input taken beyond pipeline capacity");

endmodule

bind timer_table_expiry_unit tte_checker u_tte_checker (.*);

>>> tb/timer_table_expiry_unit_tb.sv
`timescale 1ns / 100ps

module timer_table_expiry_unit_tb;
    import tte_pkg::*;

    localparam int NUM_TIMERS = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 8;
    localparam int REPORT_MAX = 10;
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam logic [DUR_MS_W-1:0] DUR_MAX = '1;
    localparam logic [HANDLE_W-1:0] HANDLE_MAX = '1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic                fired;
    } timer_reply_t;

    // Tracks the timer table and holds the replies still owed by the block.
    class timer_scoreboard;
        logic [TIME_W-1:0]   clock_us;
        logic [TIME_W-1:0]   started_at [NUM_TIMERS];
        logic [DUR_MS_W-1:0] limit_ms [NUM_TIMERS];
        bit                  expired [NUM_TIMERS];
        int unsigned         granted;
        timer_reply_t        awaited [$];
        int unsigned         faults;
        int unsigned         replies_seen;

        function new();
            clock_us = '0;
            granted = 0;
            faults = 0;
            replies_seen = 0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                started_at[i] = '0;
                limit_ms[i] = '0;
                expired[i] = 1'b0;
            end
        endfunction

        function void note_input(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h,
                                 logic [DUR_MS_W-1:0] dur);
            timer_reply_t      r;
            logic [TIME_W-1:0] gap;
            logic [63:0]       reach;
            bit                known;
            int                idx;
            r.status = ST_OK;
            r.handle = h;
            r.fired = 1'b0;
            idx = int'(h);
            known = (idx < int'(granted)) && (idx < NUM_TIMERS);
            case (op)
                OP_ALLOC: begin
                    if (granted >= NUM_TIMERS) begin
                        r.status = ST_FULL;
                        r.handle = '0;
                    end else begin
                        r.handle = HANDLE_W'(granted);
                        granted++;
                    end
                end
                OP_SET: begin
                    if (!known) begin
                        r.status = ST_BAD_HANDLE;
                    end else begin
                        limit_ms[idx] = dur;
                        expired[idx] = 1'b0;
                    end
                end
                OP_RESTART: begin
                    if (!known) begin
                        r.status = ST_BAD_HANDLE;
                    end else begin
                        started_at[idx] = clock_us;
                        expired[idx] = 1'b0;
                    end
                end
                OP_QUERY: begin
                    if (!known) begin
                        r.status = ST_BAD_HANDLE;
                    end else begin
                        // The difference wraps at 32 bits before it is widened.
                        gap = clock_us - started_at[idx];
                        reach = 64'(limit_ms[idx]) * 64'(US_PER_MS);
                        if (64'(gap) > reach) begin
                            expired[idx] = 1'b1;
                        end
                        r.fired = expired[idx];
                    end
                end
                OP_TICK: begin
                    clock_us = clock_us + 1'b1;
                end
                default: begin
                end
            endcase
            awaited.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status,
                                   logic [HANDLE_W-1:0] hout, logic fired);
            timer_reply_t want;
            replies_seen++;
            if (awaited.size() == 0) begin
                faults++;
                if (faults <= REPORT_MAX) begin
                    $display("result %0d arrived with no transaction waiting: status %0d handle %0d fired %0d",
                             replies_seen, status, hout, fired);
                end
                return;
            end
            want = awaited.pop_front();
            if (want.status !== status || want.handle !== hout || want.fired !== fired) begin
                faults++;
                if (faults <= REPORT_MAX) begin
                    $display("result %0d: status exp %0d got %0d, handle exp %0d got %0d, fired exp %0d got %0d",
                             replies_seen, want.status, status, want.handle, hout,
                             want.fired, fired);
                end
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [OP_W-1:0]     s_op;
    logic [HANDLE_W-1:0] s_timer_handle;
    logic [DUR_MS_W-1:0] s_duration_ms;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [HANDLE_W-1:0] m_handle_out;
    logic                m_fired;

    timer_scoreboard book;
    bit              last_stretch;
    bit              hold_wanted;
    int              stall_cycles;

    timer_table_expiry_unit #(
        .NUM_TIMERS(NUM_TIMERS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_timer_handle(s_timer_handle),
        .s_duration_ms(s_duration_ms),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_handle_out(m_handle_out),
        .m_fired(m_fired)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!last_stretch && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            book.check_result(m_status, m_handle_out, m_fired);
        end
    end

    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_valid && s_ready === 1'b1)
                || (m_valid === 1'b1 && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timer_table_expiry_unit: mismatch");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] h,
                             input logic [DUR_MS_W-1:0] dur);
        s_valid <= 1'b1;
        s_op <= op;
        s_timer_handle <= h;
        s_duration_ms <= dur;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        book.note_input(op, h, dur);
    endtask

    task automatic pause_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic wait_for_replies();
        s_valid <= 1'b0;
        while (book.outstanding() != 0) @(posedge aclk);
    endtask

    // Random operations on a full table. Ticks often come in long runs so that
    // timers with one-millisecond durations get a chance to expire; restarts
    // mostly hit the lower half of the table so the upper half keeps aging.
    task automatic random_items(input int count, input bit with_gaps);
        int                  done;
        int                  pick;
        int                  sel;
        int                  burst;
        logic [OP_W-1:0]     op;
        logic [HANDLE_W-1:0] h;
        logic [DUR_MS_W-1:0] dur;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            burst = 1;
            h = HANDLE_W'($urandom_range(0, 2**HANDLE_W - 1));
            if ($urandom_range(0, 4) != 0) begin
                h = HANDLE_W'($urandom_range(0, NUM_TIMERS - 1));
            end
            dur = DUR_MS_W'($urandom_range(0, 2**DUR_MS_W - 1));
            if (pick < 3) begin
                op = OP_ALLOC;
            end else if (pick < 15) begin
                op = OP_SET;
                sel = $urandom_range(0, 19);
                if (sel < 10) begin
                    dur = '0;
                end else if (sel < 15) begin
                    dur = DUR_MS_W'(1);
                end else if (sel < 17) begin
                    dur = DUR_MS_W'(2);
                end
            end else if (pick < 20) begin
                op = OP_RESTART;
                if ($urandom_range(0, 4) != 0) begin
                    h = HANDLE_W'($urandom_range(0, NUM_TIMERS / 2 - 1));
                end
            end else if (pick < 58) begin
                op = OP_QUERY;
            end else if (pick < 61) begin
                op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            end else begin
                op = OP_TICK;
                if ($urandom_range(0, 9) == 0) begin
                    burst = $urandom_range(20, 80);
                end
            end
            while (burst > 0 && done < count) begin
                if (with_gaps && $urandom_range(0, 9) == 0) begin
                    pause_sender($urandom_range(1, 10));
                end
                send_item(op, h, dur);
                done++;
                burst--;
            end
        end
    endtask

    initial begin
        book = new();
        last_stretch = 1'b0;
        hold_wanted = 1'b0;
        stall_cycles = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_op <= OP_ALLOC;
        s_timer_handle <= '0;
        s_duration_ms <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Handles used before any allocation, and the unused op codes.
        send_item(OP_QUERY, '0, '0);
        send_item(OP_RESTART, '0, '0);
        send_item(OP_SET, HANDLE_MAX, DUR_MAX);
        send_item(OP_SPARE_LO, HANDLE_MAX, DUR_MAX);
        send_item(OP_SPARE_HI, '0, '0);
        // A fresh handle has not fired; one tick later a zero duration has.
        send_item(OP_ALLOC, HANDLE_MAX, '0);
        send_item(OP_QUERY, '0, '0);
        send_item(OP_TICK, '0, '0);
        send_item(OP_QUERY, '0, '0);
        // Setting a duration clears the sticky flag but keeps the start time.
        send_item(OP_SET, '0, DUR_MAX);
        send_item(OP_QUERY, '0, '0);
        // A new entry starts at time zero, so it is already one tick old.
        send_item(OP_ALLOC, '0, '0);
        send_item(OP_QUERY, HANDLE_W'(1), '0);
        send_item(OP_RESTART, HANDLE_W'(1), '0);
        send_item(OP_QUERY, HANDLE_W'(1), '0);
        for (int i = 2; i < NUM_TIMERS; i++) begin
            send_item(OP_ALLOC, '0, '0);
        end
        // Table full, then a handle past the table.
        send_item(OP_ALLOC, HANDLE_MAX, DUR_MAX);
        send_item(OP_QUERY, HANDLE_W'(NUM_TIMERS), '0);
        send_item(OP_W'(OP_SPARE_LO + 1'b1), HANDLE_W'(42), '0);
        wait_for_replies();

        random_items(700, 1'b1);

        // Long result-side hold-off while transactions keep coming.
        hold_wanted = 1'b1;
        random_items(30, 1'b0);
        wait_for_replies();

        random_items(720, 1'b1);

        last_stretch = 1'b1;
        random_items(200, 1'b0);

        wait_for_replies();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (book.faults == 0 && book.outstanding() == 0) begin
            $display("timer_table_expiry_unit: match");
        end else begin
            $display("timer_table_expiry_unit: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/tte_pkg.sv
rtl/core/tte_store.sv
rtl/core/timer_table_expiry_unit.sv
rtl/core/tte_checker.sv
tb/timer_table_expiry_unit_tb.sv
